// ===== hdl/key_value_list_table_core_assert.svh =====
// Assertion macros for the key/value list table core.
`ifndef KEY_VALUE_LIST_TABLE_CORE_ASSERT_SVH
`define KEY_VALUE_LIST_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define KVLT_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("key/value list table assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define KVLT_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("key/value list table assertion failed");
`else
`define KVLT_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define KVLT_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hdl/kvlt_pkg.sv =====
// Shared constants, codes and control types of the key/value list table.
`default_nettype none

package kvlt_pkg;

    // Table size and the internal widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int REQ_W     = 3;
    localparam int POS_IN_W  = 7;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int POS_OUT_W = 6;
    localparam int COUNT_W   = 7;
    localparam int ENTRY_W   = KEY_W + VAL_W;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH      = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_REMOVE    = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_POP       = REQ_W'(2);
    localparam logic [REQ_W-1:0] REQ_GET       = REQ_W'(3);
    localparam logic [REQ_W-1:0] REQ_FIND_PAIR = REQ_W'(4);
    localparam logic [REQ_W-1:0] REQ_FIND_KEY  = REQ_W'(5);

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_OOB      = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_FULL     = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_NOTFOUND = STAT_W'(3);

    // How the result payload is formed.
    localparam logic [1:0] RES_PLAIN   = 2'd0;
    localparam logic [1:0] RES_FOUND   = 2'd1;
    localparam logic [1:0] RES_GET_OK  = 2'd2;
    localparam logic [1:0] RES_GET_BAD = 2'd3;

    // Start value of the walking index.
    localparam logic [1:0] IDX_ZERO     = 2'd0;
    localparam logic [1:0] IDX_POS      = 2'd1;
    localparam logic [1:0] IDX_POS_NEXT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic [1:0]        idx_src;
        logic              key_only;
        logic              shift;
        logic              step;
        logic              push;
        logic              pop;
        logic              emit;
        logic [STAT_W-1:0] st;
        logic [1:0]        kind;
    } kvlt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_oob;
        logic more;
        logic pending;
        logic hit;
    } kvlt_stat_t;

endpackage

`default_nettype wire

// ===== hdl/key_value_list_table_core.sv =====
// Top level of the key/value list table: controller, datapath and checks.
`default_nettype none
`include "key_value_list_table_core_assert.svh"

// The block holds an ordered list of up to DEPTH (64) key/value pairs in a
// single-port-write, registered-read table memory and serves one request at
// a time. A request beat is taken at a rising edge where start is high and
// busy is low; its result beat is registered at the edge where the work
// ends and appears on status, position_out, key_out, value_out and
// count_out, marked by done for that one cycle only. The receiver cannot
// stall, so it must capture the result beat whenever done is high. Push,
// pop, any rejected request and the unused request codes return their beat
// in the cycle after acceptance. Get loads the index, reads the entry into
// the read register in S_GET_RD and registers the result in S_GET_OUT.
// Remove at index p walks the memory once, moving one entry down per
// cycle. Find-pair and find-key read one entry per cycle from index zero
// and stop at the first match, or answer not-found once every entry below
// the count has been read; these walks through the single memory read
// port are the slowest requests, worst on a full table. busy stays high
// from acceptance until the edge that produces the result, and a new beat
// can be taken in the same cycle that done is shown. The table contents
// are not cleared at reset; only entries below the count are ever read.
module key_value_list_table_core
    import kvlt_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [REQ_W-1:0]            req_type,
    input  wire logic [POS_IN_W-1:0]         position_in,
    input  wire logic [KEY_W-1:0]            entry_key,
    input  wire logic signed [VAL_W-1:0]     entry_value,
    output logic                             done,
    output logic [STAT_W-1:0]                status,
    output logic [POS_OUT_W-1:0]             position_out,
    output logic [KEY_W-1:0]                 key_out,
    output logic signed [VAL_W-1:0]          value_out,
    output logic [COUNT_W-1:0]               count_out
);

    kvlt_cmd_t  cmd;
    kvlt_stat_t stat;
    logic       push_when_full;

    // The controller sequences each request; it sees the table only
    // through the status bundle.
    kvlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // The datapath owns the entry memory, the count, the walking index and
    // the registered result beat.
    kvlt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .position_in  (position_in),
        .entry_key    (entry_key),
        .entry_value  (entry_value),
        .done         (done),
        .status       (status),
        .position_out (position_out),
        .key_out      (key_out),
        .value_out    (value_out),
        .count_out    (count_out)
    );

    // A push beat is taken while the table already holds DEPTH entries.
    assign push_when_full = start && !busy && (req_type == REQ_PUSH) &&
                            (count_out == COUNT_W'(DEPTH));

    // A push into a full table is refused in the very next cycle.
    `KVLT_ASSERT_NXT(a_push_full, clk, rst_n, push_when_full, done && status == ST_FULL)

    // Every result is produced on the edge that returns the controller to idle.
    `KVLT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // The entry count only moves together with a result beat.
    `KVLT_ASSERT_IMP(a_count_moves, clk, rst_n, !$stable(count_out), done)

endmodule

`default_nettype wire

// ===== hdl/kvlt_dp.sv =====
// Datapath of the key/value list table: entry memory, count, walking index, result registers.
`default_nettype none

module kvlt_dp
    import kvlt_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kvlt_cmd_t                   cmd,
    output kvlt_stat_t                       stat,
    input  wire logic [POS_IN_W-1:0]         position_in,
    input  wire logic [KEY_W-1:0]            entry_key,
    input  wire logic signed [VAL_W-1:0]     entry_value,
    output logic                             done,
    output logic [STAT_W-1:0]                status,
    output logic [POS_OUT_W-1:0]             position_out,
    output logic [KEY_W-1:0]                 key_out,
    output logic signed [VAL_W-1:0]          value_out,
    output logic [COUNT_W-1:0]               count_out
);

    logic [ENTRY_W-1:0]          mem [DEPTH];
    logic [ENTRY_W-1:0]          rdata_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_next;
    logic [CNT_W-1:0]            idx_d_reg;
    logic [CNT_W-1:0]            idx_wr;
    logic                        step_d_reg;
    logic                        shift_reg;
    logic                        key_only_reg;
    logic [KEY_W-1:0]            key_reg;
    logic [VAL_W-1:0]            val_reg;
    logic                        done_reg;
    logic [STAT_W-1:0]           status_reg;
    logic [POS_OUT_W-1:0]        pos_reg;
    logic [KEY_W-1:0]            key_out_reg;
    logic signed [VAL_W-1:0]     val_out_reg;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ENTRY_W-1:0]          wr_data;
    logic                        match;

    // A removal writes each entry read in the previous cycle one place lower.
    assign idx_wr  = idx_d_reg - CNT_W'(1);
    assign wr_en   = cmd.push | (step_d_reg & shift_reg);
    assign wr_addr = cmd.push ? count_reg[ADDR_W-1:0] : idx_wr[ADDR_W-1:0];
    assign wr_data = cmd.push ? {entry_key, entry_value} : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.step)
        begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign match = (rdata_reg[ENTRY_W-1:VAL_W] == key_reg) &&
                   (key_only_reg || (rdata_reg[VAL_W-1:0] == val_reg));

    assign stat.full    = (count_reg >= CNT_W'(DEPTH));
    assign stat.empty   = (count_reg == '0);
    assign stat.pos_oob = (position_in >= count_reg);
    assign stat.more    = (idx_reg < count_reg);
    assign stat.pending = step_d_reg;
    assign stat.hit     = step_d_reg & match;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            case (cmd.idx_src)
                IDX_POS:      idx_next = CNT_W'(position_in);
                IDX_POS_NEXT: idx_next = CNT_W'(position_in) + CNT_W'(1);
                default:      idx_next = '0;
            endcase
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            idx_d_reg    <= '0;
            step_d_reg   <= 1'b0;
            shift_reg    <= 1'b0;
            key_only_reg <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            step_d_reg <= cmd.step;
            done_reg   <= cmd.emit;
            if (cmd.step)
            begin
                idx_d_reg <= idx_reg;
            end
            if (cmd.load)
            begin
                shift_reg    <= cmd.shift;
                key_only_reg <= cmd.key_only;
            end
            if (cmd.emit)
            begin
                status_reg <= cmd.st;
            end
        end
    end

    // Search operands and the result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= entry_key;
            val_reg <= entry_value;
        end
        if (cmd.emit)
        begin
            pos_reg <= (cmd.kind == RES_FOUND) ? POS_OUT_W'(idx_d_reg) : '0;
            case (cmd.kind)
                RES_GET_OK:
                begin
                    key_out_reg <= rdata_reg[ENTRY_W-1:VAL_W];
                    val_out_reg <= $signed(rdata_reg[VAL_W-1:0]);
                end
                RES_GET_BAD:
                begin
                    key_out_reg <= '1;
                    val_out_reg <= '1;
                end
                default:
                begin
                    key_out_reg <= '0;
                    val_out_reg <= '0;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign position_out = pos_reg;
    assign key_out      = key_out_reg;
    assign value_out    = val_out_reg;
    assign count_out    = COUNT_W'(count_reg);

endmodule

`default_nettype wire

// ===== hdl/kvlt_ctrl.sv =====
// Controller state machine of the key/value list table.
`default_nettype none

module kvlt_ctrl
    import kvlt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire kvlt_stat_t        stat,
    output kvlt_cmd_t              cmd,
    output logic                   busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SHIFT   = 3'd1;
    localparam logic [2:0] S_GET_RD  = 3'd2;
    localparam logic [2:0] S_GET_OUT = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.st     = ST_OK;
        cmd.kind   = RES_PLAIN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type) inside
                        REQ_PUSH:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.st = ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (stat.pos_oob)
                            begin
                                cmd.emit = 1'b1;
                                cmd.st   = ST_OOB;
                            end
                            else
                            begin
                                cmd.load    = 1'b1;
                                cmd.idx_src = IDX_POS_NEXT;
                                cmd.shift   = 1'b1;
                                state_next  = S_SHIFT;
                            end
                        end
                        REQ_POP:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.st = ST_OOB;
                            end
                            else
                            begin
                                cmd.pop = 1'b1;
                            end
                        end
                        REQ_GET:
                        begin
                            if (stat.pos_oob)
                            begin
                                cmd.emit = 1'b1;
                                cmd.st   = ST_OOB;
                                cmd.kind = RES_GET_BAD;
                            end
                            else
                            begin
                                cmd.load    = 1'b1;
                                cmd.idx_src = IDX_POS;
                                state_next  = S_GET_RD;
                            end
                        end
                        REQ_FIND_PAIR, REQ_FIND_KEY:
                        begin
                            cmd.load     = 1'b1;
                            cmd.idx_src  = IDX_ZERO;
                            cmd.key_only = (req_type == REQ_FIND_KEY);
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // The final moved entry is written in the same cycle as the count drops.
                if (stat.more)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GET_RD:
            begin
                cmd.step   = 1'b1;
                state_next = S_GET_OUT;
            end
            S_GET_OUT:
            begin
                cmd.emit   = 1'b1;
                cmd.kind   = RES_GET_OK;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RES_FOUND;
                    state_next = S_IDLE;
                end
                else if (!stat.more && !stat.pending)
                begin
                    cmd.emit   = 1'b1;
                    cmd.st     = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else if (stat.more)
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire
